### sv/bpwe_pkg.sv
package bpwe_pkg;

  localparam int PW_W       = 16;
  localparam int MAX_SYMS   = 10;
  localparam int SYM_IDX_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    SYM_IDLE = 2'd0,
    SYM_LO   = 2'd1,
    SYM_HI   = 2'd2
  } sym_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MSB_FIRST      = 3'd0,
    CFG_FRAME_BITS     = 3'd1,
    CFG_NO_END_PADDING = 3'd2,
    CFG_NORMAL_WIDTH   = 3'd3,
    CFG_ALONE_WIDTH    = 3'd4,
    CFG_END_WIDTH      = 3'd5,
    CFG_LOW_WIDTH      = 3'd6
  } cfg_idx_t;

  localparam logic [PW_W-1:0] RST_NORMAL_WIDTH = 16'd17;
  localparam logic [PW_W-1:0] RST_ALONE_WIDTH  = 16'd17;
  localparam logic [PW_W-1:0] RST_END_WIDTH    = 16'd17;
  localparam logic [PW_W-1:0] RST_LOW_WIDTH    = 16'd8;

  typedef struct packed {
    logic            msb_first;
    logic            frame_bits;
    logic            no_end_padding;
    logic [PW_W-1:0] normal_width;
    logic [PW_W-1:0] alone_width;
    logic [PW_W-1:0] end_width;
    logic [PW_W-1:0] low_width;
  } cfg_t;

  // One classified byte: a high flag per slot in send order, the index of its last slot
  // and the end-of-transmission mark.
  typedef struct packed {
    logic [MAX_SYMS-1:0]  sym_hi;
    logic [SYM_IDX_W-1:0] last_idx;
    logic                 final_byte;
  } job_t;

  function automatic logic [PW_W-1:0] slot_width(sym_t prev, sym_t cur, sym_t nxt, cfg_t cfg);
    logic [PW_W-1:0] w;
    if (cur != SYM_HI) begin
      w = cfg.low_width;
    end else if (nxt == SYM_HI) begin
      w = cfg.normal_width;
    end else if (prev != SYM_HI) begin
      w = cfg.alone_width;
    end else begin
      w = cfg.end_width;
    end
    return w;
  endfunction

endpackage

### sv/bpwe_front.sv
module bpwe_front
  import bpwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  logic       valid_r, valid_nxt;
  job_t       job_r, job_nxt;
  logic [7:0] b;
  logic       accept;

  assign in_ready  = !valid_r || job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = cfg.msb_first ? in_data_byte[i] : in_data_byte[7-i];
    end
    job_nxt            = job_r;
    job_nxt.final_byte = in_final_byte;
    if (cfg.frame_bits) begin
      job_nxt.sym_hi[0] = 1'b1;
      for (int k = 0; k < 8; k++) begin
        job_nxt.sym_hi[k+1] = ~b[7-k];
      end
      job_nxt.sym_hi[9] = 1'b0;
      job_nxt.last_idx  = SYM_IDX_W'(9);
    end else begin
      for (int k = 0; k < 8; k++) begin
        job_nxt.sym_hi[k] = ~b[7-k];
      end
      job_nxt.sym_hi[9:8] = 2'b00;
      job_nxt.last_idx    = SYM_IDX_W'(7);
    end
    valid_nxt = accept | (valid_r & ~job_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

endmodule

### sv/bpwe_fifo.sv
module bpwe_fifo
  import bpwe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic head_valid,
  input  logic pop,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### sv/bpwe_back.sv
module bpwe_back
  import bpwe_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            head_valid,
  input  job_t            head_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PW_W-1:0] out_pulse_width,
  output logic            out_run_last,
  output logic            out_frame_done
);

  typedef enum logic [3:0] {
    PH_SYM   = 4'b0001,
    PH_TAIL0 = 4'b0010,
    PH_TAIL1 = 4'b0100,
    PH_TAIL2 = 4'b1000
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic                 held_valid_r, held_valid_nxt;
  sym_t                 held_r, held_nxt;
  sym_t                 prev_r, prev_nxt;
  logic [SYM_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PW_W-1:0]      pw_r, pw_nxt;
  logic                 run_last_r, run_last_nxt;
  logic                 done_r, done_nxt;
  logic                 adv;
  sym_t                 cur_sym;

  assign adv             = head_valid && (!out_valid_r || out_ready);
  assign cur_sym         = head_job.sym_hi[idx_r] ? SYM_HI : SYM_LO;
  assign out_valid       = out_valid_r;
  assign out_pulse_width = pw_r;
  assign out_run_last    = run_last_r;
  assign out_frame_done  = done_r;

  always_comb begin
    phase_nxt      = phase_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    prev_nxt       = prev_r;
    idx_nxt        = idx_r;
    pw_nxt         = pw_r;
    run_last_nxt   = run_last_r;
    done_nxt       = done_r;
    pop            = 1'b0;
    out_valid_nxt  = out_valid_r & ~out_ready;
    if (adv) begin
      out_valid_nxt = 1'b1;
      run_last_nxt  = 1'b0;
      done_nxt      = 1'b0;
      unique case (phase_r)
        PH_SYM: begin
          if (!held_valid_r) begin
            // The leading zero slot goes out while the first symbol is loaded.
            pw_nxt         = '0;
            held_nxt       = cur_sym;
            held_valid_nxt = 1'b1;
            prev_nxt       = SYM_IDLE;
            idx_nxt        = idx_r + SYM_IDX_W'(1);
          end else begin
            pw_nxt   = slot_width(prev_r, held_r, cur_sym, cfg);
            prev_nxt = held_r;
            held_nxt = cur_sym;
            if (idx_r == head_job.last_idx) begin
              idx_nxt = '0;
              if (head_job.final_byte) begin
                phase_nxt = PH_TAIL0;
              end else begin
                run_last_nxt = 1'b1;
                pop          = 1'b1;
              end
            end else begin
              idx_nxt = idx_r + SYM_IDX_W'(1);
            end
          end
        end
        PH_TAIL0: begin
          pw_nxt    = slot_width(prev_r, held_r, SYM_IDLE, cfg);
          phase_nxt = PH_TAIL1;
        end
        PH_TAIL1: begin
          pw_nxt    = cfg.no_end_padding ? '0 : cfg.low_width;
          phase_nxt = PH_TAIL2;
        end
        PH_TAIL2: begin
          pw_nxt         = '0;
          run_last_nxt   = 1'b1;
          done_nxt       = 1'b1;
          pop            = 1'b1;
          held_valid_nxt = 1'b0;
          held_nxt       = SYM_IDLE;
          prev_nxt       = SYM_IDLE;
          phase_nxt      = PH_SYM;
        end
        default: begin
          phase_nxt = PH_SYM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SYM;
      held_valid_r <= 1'b0;
      held_r       <= SYM_IDLE;
      prev_r       <= SYM_IDLE;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
      prev_r       <= prev_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pw_r       <= pw_nxt;
    run_last_r <= run_last_nxt;
    done_r     <= done_nxt;
  end

endmodule

### sv/byte_to_pulse_width_encoder.sv
// Byte to pulse width encoder. Each byte accepted on the in_ channel becomes one
// timer compare width per bit slot on the out_ channel, eight slots per byte, or ten
// when start and stop slots are enabled. The first byte of a transmission adds a
// leading zero slot whose cost is hidden by a one-symbol lookahead, and the byte
// marked final adds three closing slots. out_run_last marks the last slot caused by
// a byte, out_frame_done the final slot of a transmission.
// A byte produces 8 to 13 slots. The output sequencer emits one slot per cycle while
// the queue holds a byte and out_ready does not hold the output register. The first
// slot of a byte passes the classify stage, the two-entry queue and the output
// register in that order.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while no transaction is in flight, which the block does not enforce.
// Reset restores the register defaults, empties the queue and arms the leading zero
// slot. When out_ready is low the output register holds its slot, the sequencer
// stops, and the input keeps accepting until the queue and classify stage are full.
module byte_to_pulse_width_encoder
  import bpwe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_final_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PW_W-1:0]       out_pulse_width,
  output logic                  out_run_last,
  output logic                  out_frame_done
);

  cfg_t cfg_r, cfg_nxt;
  logic f_valid, f_ready;
  job_t f_job;
  logic q_valid, q_pop;
  job_t q_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MSB_FIRST:      cfg_nxt.msb_first      = cfg_data[0];
        CFG_FRAME_BITS:     cfg_nxt.frame_bits     = cfg_data[0];
        CFG_NO_END_PADDING: cfg_nxt.no_end_padding = cfg_data[0];
        CFG_NORMAL_WIDTH:   cfg_nxt.normal_width   = cfg_data[PW_W-1:0];
        CFG_ALONE_WIDTH:    cfg_nxt.alone_width    = cfg_data[PW_W-1:0];
        CFG_END_WIDTH:      cfg_nxt.end_width      = cfg_data[PW_W-1:0];
        CFG_LOW_WIDTH:      cfg_nxt.low_width      = cfg_data[PW_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.msb_first      <= 1'b1;
      cfg_r.frame_bits     <= 1'b0;
      cfg_r.no_end_padding <= 1'b0;
      cfg_r.normal_width   <= RST_NORMAL_WIDTH;
      cfg_r.alone_width    <= RST_ALONE_WIDTH;
      cfg_r.end_width      <= RST_END_WIDTH;
      cfg_r.low_width      <= RST_LOW_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bpwe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .job_valid     (f_valid),
    .job_ready     (f_ready),
    .job           (f_job)
  );

  bpwe_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_job   (q_job)
  );

  bpwe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (q_valid),
    .head_job        (q_job),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pulse_width (out_pulse_width),
    .out_run_last    (out_run_last),
    .out_frame_done  (out_frame_done)
  );

endmodule
